/* hw/rtl/tsuie_pkg.sv */
package tsuie_pkg;

  // default sizes
  localparam int SET_DEPTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 16;

  // port field widths
  localparam int ACT_W   = 3;
  localparam int FIELD_W = 16;

  // command codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MEMBER = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DUMP   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_UNION  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_INTER  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DIFF   = 3'd5;

endpackage

/* hw/rtl/tsuie_store.sv */
module tsuie_store #(
  parameter int SET_DEPTH   = tsuie_pkg::SET_DEPTH_DEF,
  parameter int VALUE_WIDTH = tsuie_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [VALUE_WIDTH-1:0]         wr_data,
  input  logic [$clog2(SET_DEPTH)-1:0]   rd_addr,
  output logic [VALUE_WIDTH-1:0]         rd_data,
  output logic [$clog2(SET_DEPTH+1)-1:0] count
);

  localparam int IDX_W = $clog2(SET_DEPTH);
  localparam int CNT_W = $clog2(SET_DEPTH+1);

  logic [VALUE_WIDTH-1:0] mem_r [SET_DEPTH];
  logic [CNT_W-1:0]       count_r;

  // append at the fill point; caller never writes a full set
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[count_r[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (wr_en) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  assign rd_data = mem_r[rd_addr];
  assign count   = count_r;

endmodule

/* hw/rtl/tsuie_seq.sv */
module tsuie_seq #(
  parameter int SET_DEPTH   = tsuie_pkg::SET_DEPTH_DEF,
  parameter int VALUE_WIDTH = tsuie_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // command side
  input  logic                             start,
  output logic                             busy,
  input  logic [tsuie_pkg::ACT_W-1:0]      in_action,
  input  logic                             in_set_select,
  input  logic [tsuie_pkg::FIELD_W-1:0]    in_element_value,
  // set stores
  input  logic [$clog2(SET_DEPTH+1)-1:0]   cnt_a,
  input  logic [$clog2(SET_DEPTH+1)-1:0]   cnt_b,
  input  logic [VALUE_WIDTH-1:0]           rd_a,
  input  logic [VALUE_WIDTH-1:0]           rd_b,
  output logic [$clog2(SET_DEPTH)-1:0]     addr_a,
  output logic [$clog2(SET_DEPTH)-1:0]     addr_b,
  output logic                             wr_a,
  output logic                             wr_b,
  output logic [VALUE_WIDTH-1:0]           wr_data,
  // result side
  output logic                             out_strobe,
  output logic [tsuie_pkg::FIELD_W-1:0]    out_result_value,
  output logic                             out_source_set,
  output logic                             out_is_member,
  output logic                             out_empty_result,
  output logic                             out_full_error,
  output logic                             out_last_of_run
);

  localparam int IDX_W  = $clog2(SET_DEPTH);
  localparam int CNT_W  = $clog2(SET_DEPTH+1);
  localparam int OUT_W  = tsuie_pkg::FIELD_W;
  localparam int KEEP_W = (VALUE_WIDTH < OUT_W) ? VALUE_WIDTH : OUT_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FETCH, S_INNER, S_FINISH} state_t;

  state_t                      state_r;
  logic [tsuie_pkg::ACT_W-1:0] act_r;
  logic [VALUE_WIDTH-1:0]      key_r;
  logic                        q_is_b_r;   // inner set is B, outer set is A
  logic                        has_q_r;    // pass filters against inner set
  logic                        keep_in_r;  // keep elements found in inner set
  logic                        src_r;
  logic                        pass_r;
  logic [CNT_W-1:0]            i_r;
  logic [CNT_W-1:0]            j_r;
  // one-deep hold so the final beat can carry last_of_run
  logic                        pend_v_r;
  logic [VALUE_WIDTH-1:0]      pend_val_r;
  logic                        pend_src_r;
  logic                        out_strobe_r;
  logic                        out_strobe_nxt;
  logic [OUT_W-1:0]            out_value_r;
  logic                        out_src_r;
  logic                        out_mem_r;
  logic                        out_empty_r;
  logic                        out_full_r;
  logic                        out_last_r;

  logic [CNT_W-1:0]       pc;
  logic [CNT_W-1:0]       qc;
  logic [VALUE_WIDTH-1:0] p_data;
  logic [VALUE_WIDTH-1:0] q_data;
  logic                   hit;
  logic                   scan_end;
  logic                   outer_end;
  logic                   found;
  logic                   sel_full;
  logic                   cand_go;
  logic [VALUE_WIDTH-1:0] cand_val;

  // outer / inner set routing
  assign pc     = q_is_b_r ? cnt_a : cnt_b;
  assign qc     = q_is_b_r ? cnt_b : cnt_a;
  assign p_data = q_is_b_r ? rd_a : rd_b;
  assign q_data = q_is_b_r ? rd_b : rd_a;
  assign addr_a = q_is_b_r ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];
  assign addr_b = q_is_b_r ? j_r[IDX_W-1:0] : i_r[IDX_W-1:0];

  // shared equality compare against the held key
  assign hit       = (q_data == key_r);
  assign scan_end  = (j_r == qc);
  assign outer_end = (i_r == pc);
  assign found     = !scan_end && hit;
  assign sel_full  = (qc == CNT_W'(SET_DEPTH));

  // insert appends when the scan misses and there is room
  assign wr_data = key_r;
  assign wr_a = (state_r == S_SCAN) && (act_r == tsuie_pkg::ACT_INSERT) &&
                scan_end && !sel_full && !q_is_b_r;
  assign wr_b = (state_r == S_SCAN) && (act_r == tsuie_pkg::ACT_INSERT) &&
                scan_end && !sel_full && q_is_b_r;

  // element that qualifies for the run this cycle
  always_comb begin
    cand_go  = 1'b0;
    cand_val = key_r;
    if (state_r == S_FETCH && !outer_end && !has_q_r) begin
      cand_go  = 1'b1;
      cand_val = p_data;
    end else if (state_r == S_INNER && (scan_end || hit) && (found == keep_in_r)) begin
      cand_go  = 1'b1;
    end
  end

  // a beat goes out on a scan answer, a closing beat or a pushed-out held element
  assign out_strobe_nxt = ((state_r == S_SCAN) && (scan_end || hit)) ||
                          (state_r == S_FINISH) || (cand_go && pend_v_r);

  // sequencer and registered result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      act_r        <= tsuie_pkg::ACT_INSERT;
      q_is_b_r     <= 1'b0;
      has_q_r      <= 1'b0;
      keep_in_r    <= 1'b0;
      src_r        <= 1'b0;
      pass_r       <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            act_r     <= in_action;
            key_r     <= VALUE_WIDTH'(in_element_value[KEEP_W-1:0]);
            pend_v_r  <= 1'b0;
            src_r     <= 1'b0;
            pass_r    <= 1'b0;
            keep_in_r <= 1'b0;
            has_q_r   <= 1'b0;
            i_r       <= '0;
            j_r       <= '0;
            unique case (in_action) inside
              tsuie_pkg::ACT_INSERT, tsuie_pkg::ACT_MEMBER: begin
                q_is_b_r <= in_set_select;
                state_r  <= S_SCAN;
              end
              tsuie_pkg::ACT_DUMP, tsuie_pkg::ACT_UNION: begin
                q_is_b_r <= 1'b1;
                state_r  <= S_FETCH;
              end
              tsuie_pkg::ACT_INTER: begin
                q_is_b_r  <= 1'b1;
                has_q_r   <= 1'b1;
                keep_in_r <= 1'b1;
                state_r   <= S_FETCH;
              end
              tsuie_pkg::ACT_DIFF: begin
                q_is_b_r <= !in_set_select;
                has_q_r  <= 1'b1;
                state_r  <= S_FETCH;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        // linear search of the selected set for the key
        S_SCAN: begin
          if (scan_end || hit) begin
            out_value_r  <= OUT_W'(key_r);
            out_src_r    <= 1'b0;
            out_mem_r    <= (act_r == tsuie_pkg::ACT_MEMBER) && found;
            out_empty_r  <= 1'b0;
            out_full_r   <= (act_r == tsuie_pkg::ACT_INSERT) && scan_end && sel_full;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            j_r <= j_r + CNT_W'(1);
          end
        end

        // next outer element, or move to the second pass or to the closing beat
        S_FETCH: begin
          if (outer_end) begin
            if (!pass_r && (act_r == tsuie_pkg::ACT_DUMP ||
                            act_r == tsuie_pkg::ACT_UNION)) begin
              pass_r    <= 1'b1;
              i_r       <= '0;
              q_is_b_r  <= 1'b0;
              has_q_r   <= (act_r == tsuie_pkg::ACT_UNION);
              keep_in_r <= 1'b0;
              src_r     <= (act_r == tsuie_pkg::ACT_DUMP);
            end else begin
              state_r <= S_FINISH;
            end
          end else begin
            key_r <= p_data;
            if (has_q_r) begin
              j_r     <= '0;
              state_r <= S_INNER;
            end else begin
              i_r <= i_r + CNT_W'(1);
            end
          end
        end

        // search the inner set for the outer element
        S_INNER: begin
          if (scan_end || hit) begin
            i_r     <= i_r + CNT_W'(1);
            state_r <= S_FETCH;
          end else begin
            j_r <= j_r + CNT_W'(1);
          end
        end

        // closing beat: held element, or the empty marker
        S_FINISH: begin
          out_mem_r    <= 1'b0;
          out_full_r   <= 1'b0;
          out_last_r   <= 1'b1;
          if (pend_v_r) begin
            out_value_r <= OUT_W'(pend_val_r);
            out_src_r   <= pend_src_r;
            out_empty_r <= 1'b0;
          end else begin
            out_value_r <= '0;
            out_src_r   <= 1'b0;
            out_empty_r <= 1'b1;
          end
          pend_v_r <= 1'b0;
          state_r  <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase

      // qualifying element pushes the held one out as a beat
      if (cand_go) begin
        pend_v_r   <= 1'b1;
        pend_val_r <= cand_val;
        pend_src_r <= src_r;
        if (pend_v_r) begin
          out_value_r  <= OUT_W'(pend_val_r);
          out_src_r    <= pend_src_r;
          out_mem_r    <= 1'b0;
          out_empty_r  <= 1'b0;
          out_full_r   <= 1'b0;
          out_last_r   <= 1'b0;
        end
      end
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_result_value = out_value_r;
  assign out_source_set   = out_src_r;
  assign out_is_member    = out_mem_r;
  assign out_empty_result = out_empty_r;
  assign out_full_error   = out_full_r;
  assign out_last_of_run  = out_last_r;

endmodule

/* hw/rtl/two_set_union_intersect_engine.sv */
// Two-set engine: keeps sets A and B (up to SET_DEPTH distinct values each, in
// insertion order) and runs insert, membership, dump, union, intersection and
// difference commands. A command is taken when start is high and busy is low;
// busy then stays high until the cycle that carries its last result beat.
// Results leave one per cycle at most, each valid for exactly one cycle under
// out_strobe, and out_last_of_run marks the final beat of a command; the
// receiver cannot stall, so it must take every strobed beat. All work goes
// through one equality comparator that steps over the stored elements one per
// cycle: insert and membership scan one set, a dump reads A and then B,
// intersection and difference search the inner set for each outer element,
// and union passes all of A and then searches A for each element of B.
// Unused command codes are dropped with no result. Reset empties both sets.
module two_set_union_intersect_engine #(
  parameter int SET_DEPTH   = tsuie_pkg::SET_DEPTH_DEF,
  parameter int VALUE_WIDTH = tsuie_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tsuie_pkg::ACT_W-1:0]   in_action,
  input  logic                          in_set_select,
  input  logic [tsuie_pkg::FIELD_W-1:0] in_element_value,
  output logic                          out_strobe,
  output logic [tsuie_pkg::FIELD_W-1:0] out_result_value,
  output logic                          out_source_set,
  output logic                          out_is_member,
  output logic                          out_empty_result,
  output logic                          out_full_error,
  output logic                          out_last_of_run
);

  localparam int IDX_W = $clog2(SET_DEPTH);
  localparam int CNT_W = $clog2(SET_DEPTH+1);

  logic [CNT_W-1:0]       cnt_a;
  logic [CNT_W-1:0]       cnt_b;
  logic [VALUE_WIDTH-1:0] rd_a;
  logic [VALUE_WIDTH-1:0] rd_b;
  logic [IDX_W-1:0]       addr_a;
  logic [IDX_W-1:0]       addr_b;
  logic                   wr_a;
  logic                   wr_b;
  logic [VALUE_WIDTH-1:0] wr_data;

  // set A
  tsuie_store #(
    .SET_DEPTH   (SET_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_set_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_a),
    .wr_data (wr_data),
    .rd_addr (addr_a),
    .rd_data (rd_a),
    .count   (cnt_a)
  );

  // set B
  tsuie_store #(
    .SET_DEPTH   (SET_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_set_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_b),
    .wr_data (wr_data),
    .rd_addr (addr_b),
    .rd_data (rd_b),
    .count   (cnt_b)
  );

  // command sequencer with the shared comparator
  tsuie_seq #(
    .SET_DEPTH   (SET_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_set_select    (in_set_select),
    .in_element_value (in_element_value),
    .cnt_a            (cnt_a),
    .cnt_b            (cnt_b),
    .rd_a             (rd_a),
    .rd_b             (rd_b),
    .addr_a           (addr_a),
    .addr_b           (addr_b),
    .wr_a             (wr_a),
    .wr_b             (wr_b),
    .wr_data          (wr_data),
    .out_strobe       (out_strobe),
    .out_result_value (out_result_value),
    .out_source_set   (out_source_set),
    .out_is_member    (out_is_member),
    .out_empty_result (out_empty_result),
    .out_full_error   (out_full_error),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
